// ===== rtl/lpht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_SLOTS = 1024;

	localparam int KEY_W    = 16;
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 10;

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int ENTRY_W = 1 + KEY_W + VALUE_W;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STAT_INSERTED  = status_t'(0);
	localparam status_t STAT_FOUND     = status_t'(1);
	localparam status_t STAT_NOT_FOUND = status_t'(2);
	localparam status_t STAT_FULL      = status_t'(3);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// number of shift-subtract steps that reduce a key below the table size,
	// zero when the size is a power of two and the home slot is a plain mask
	function automatic int calc_hash_steps();
		int s;
		s = 0;
		if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) != 0) begin
			for (int i = 0; i <= KEY_W; i++) begin
				if ((longint'(TABLE_SLOTS) << i) < (longint'(1) << KEY_W)) begin
					s = i + 1;
				end
			end
		end
		return s;
	endfunction

	localparam int HASH_STEPS = calc_hash_steps();
	localparam int HCNT_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

	localparam logic [KEY_W-1:0] HASH_DIV_INIT =
		KEY_W'(longint'(TABLE_SLOTS) << ((HASH_STEPS > 0) ? HASH_STEPS - 1 : 0));

	typedef struct packed {
		logic clear;
		logic accept;
		logic hash_step;
		logic read_home;
		logic scan;
		logic finish;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic hit;
		logic out_free;
	} dp_sts_t;

	// low bits of a slot index, zero-extended for small tables
	function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = (IDX_W + SLOT_W)'(idx);
		return wide[SLOT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/linear_probe_hash_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing, one result per operation.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TABLE_SLOTS (1024) slots
// that marks every slot empty; in_stall stays high until it ends. Each
// operation then probes 1 to TABLE_SLOTS slots, one slot per cycle through
// the single read port of the slot RAM. For a table size that is not a power
// of two the home slot is first reduced by a shift-subtract loop, which is
// skipped at the default size. A finished result sits in an output register,
// so a new operation is taken while it waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          operation,
	input  wire logic [lpht_pkg::KEY_W-1:0]    key,
	input  wire logic [lpht_pkg::VALUE_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [lpht_pkg::STATUS_W-1:0] status,
	output logic      [lpht_pkg::SLOT_W-1:0]   slot,
	output logic      [lpht_pkg::VALUE_W-1:0]  found_value
);

	lpht_pkg::dp_cmd_t cmd;
	lpht_pkg::dp_sts_t sts;
	lpht_pkg::status_t status_w;

	lpht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	lpht_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status_w),
		.slot       (slot),
		.found_value(found_value)
	);

	assign status = status_w;

endmodule
`default_nettype wire

// ===== rtl/lpht_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/lpht_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_datapath
// Operand registers, home slot reduction, probe index, slot store and the
// result and output registers.
// ----------------------------------------------------------------------------
module lpht_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lpht_pkg::dp_cmd_t             cmd,
	output lpht_pkg::dp_sts_t                  sts,
	input  wire logic                          operation,
	input  wire logic [lpht_pkg::KEY_W-1:0]    key,
	input  wire logic [lpht_pkg::VALUE_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output lpht_pkg::status_t                  status,
	output logic      [lpht_pkg::SLOT_W-1:0]   slot,
	output logic      [lpht_pkg::VALUE_W-1:0]  found_value
);

	lpht_pkg::op_t                   op_q;
	logic [lpht_pkg::KEY_W-1:0]      key_q;
	logic [lpht_pkg::VALUE_W-1:0]    value_q;
	logic [lpht_pkg::KEY_W-1:0]      rem_q;
	logic [lpht_pkg::KEY_W-1:0]      div_q;
	logic [lpht_pkg::IDX_W-1:0]      idx_q;

	lpht_pkg::status_t               res_status_q;
	logic [lpht_pkg::SLOT_W-1:0]     res_slot_q;
	logic [lpht_pkg::VALUE_W-1:0]    res_value_q;

	logic                            out_valid_q;
	lpht_pkg::status_t               status_q;
	logic [lpht_pkg::SLOT_W-1:0]     slot_q;
	logic [lpht_pkg::VALUE_W-1:0]    found_value_q;

	logic [lpht_pkg::IDX_W-1:0]      idx_inc;
	logic [lpht_pkg::IDX_W-1:0]      home;
	logic [lpht_pkg::IDX_W-1:0]      raddr;
	logic                            ram_we;
	logic [lpht_pkg::ENTRY_W-1:0]    ram_wdata;
	logic [lpht_pkg::ENTRY_W-1:0]    ram_rdata;
	logic                            rd_occ;
	logic [lpht_pkg::KEY_W-1:0]      rd_key;
	logic [lpht_pkg::VALUE_W-1:0]    rd_value;
	logic                            hit;

	assign idx_inc = (idx_q == lpht_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
	// after reduction the remainder is below the table size
	assign home    = rem_q[lpht_pkg::IDX_W-1:0];

	assign rd_occ   = ram_rdata[lpht_pkg::ENTRY_W-1];
	assign rd_key   = ram_rdata[lpht_pkg::ENTRY_W-2 -: lpht_pkg::KEY_W];
	assign rd_value = ram_rdata[lpht_pkg::VALUE_W-1:0];

	// read data always belongs to idx_q while scanning
	assign hit = (op_q == lpht_pkg::OP_LOOKUP) ? (!rd_occ || (rd_key == key_q)) : !rd_occ;

	always_comb begin
		if (cmd.scan) begin
			raddr = idx_inc;
		end else if (cmd.read_home) begin
			raddr = home;
		end else begin
			raddr = idx_q;
		end
	end

	assign ram_we    = cmd.clear || (cmd.finish && (op_q == lpht_pkg::OP_INSERT) && !rd_occ);
	assign ram_wdata = cmd.clear ? '0 : {1'b1, key_q, value_q};

	lpht_ram #(
		.WIDTH(lpht_pkg::ENTRY_W),
		.DEPTH(lpht_pkg::TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= lpht_pkg::op_t'(operation);
			key_q   <= key;
			value_q <= value;
			rem_q   <= key;
			div_q   <= lpht_pkg::HASH_DIV_INIT;
		end else if (cmd.hash_step) begin
			if (rem_q >= div_q) begin
				rem_q <= rem_q - div_q;
			end
			div_q <= div_q >> 1;
		end

		if (cmd.finish) begin
			if (hit) begin
				if (op_q == lpht_pkg::OP_INSERT) begin
					res_status_q <= lpht_pkg::STAT_INSERTED;
					res_slot_q   <= lpht_pkg::slot_field(idx_q);
					res_value_q  <= '0;
				end else if (rd_occ) begin
					res_status_q <= lpht_pkg::STAT_FOUND;
					res_slot_q   <= lpht_pkg::slot_field(idx_q);
					res_value_q  <= rd_value;
				end else begin
					res_status_q <= lpht_pkg::STAT_NOT_FOUND;
					res_slot_q   <= '0;
					res_value_q  <= '0;
				end
			end else begin
				res_status_q <= (op_q == lpht_pkg::OP_INSERT) ? lpht_pkg::STAT_FULL
					: lpht_pkg::STAT_NOT_FOUND;
				res_slot_q   <= '0;
				res_value_q  <= '0;
			end
		end

		if (cmd.load_out) begin
			status_q      <= res_status_q;
			slot_q        <= res_slot_q;
			found_value_q <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear || cmd.scan) begin
				idx_q <= idx_inc;
			end else if (cmd.read_home) begin
				idx_q <= home;
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.idx_last = (idx_q == lpht_pkg::IDX_LAST);
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign found_value = found_value_q;

	// home slot must already be reduced when the first probe is issued;
	// a power-of-two size takes the low key bits and needs no reduction
	a_home_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read_home && (lpht_pkg::HASH_STEPS > 0)) |->
		({1'b0, rem_q} < (lpht_pkg::KEY_W + 1)'(lpht_pkg::TABLE_SLOTS)))
		else $error("home slot not reduced below table size");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a pending transfer");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == lpht_pkg::STAT_NOT_FOUND || status_q == lpht_pkg::STAT_FULL))
		|-> (slot_q == '0 && found_value_q == '0))
		else $error("miss result carries slot or value");

endmodule
`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing pass, home slot reduction, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output lpht_pkg::dp_cmd_t        cmd,
	input  wire lpht_pkg::dp_sts_t   sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                       state_q;
	state_t                       state_nxt;
	logic [lpht_pkg::IDX_W-1:0]   n_q;
	logic [lpht_pkg::HCNT_W-1:0]  hcnt_q;
	logic                         probe_last;
	logic                         hash_last;

	assign probe_last = (n_q == lpht_pkg::IDX_LAST);
	assign hash_last  = (hcnt_q == lpht_pkg::HCNT_W'(lpht_pkg::HASH_STEPS - 1));

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.idx_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = (lpht_pkg::HASH_STEPS == 0) ? ST_READ : ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash_step = 1'b1;
				if (hash_last) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_home = 1'b1;
				state_nxt     = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || probe_last) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			n_q     <= '0;
			hcnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) begin
				hcnt_q <= '0;
			end else if (cmd.hash_step) begin
				hcnt_q <= hcnt_q + 1'b1;
			end
			if (cmd.read_home) begin
				n_q <= '0;
			end else if (cmd.scan) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted");

	a_hash_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH) |->
		((lpht_pkg::HCNT_W + 1)'(hcnt_q) < (lpht_pkg::HCNT_W + 1)'(lpht_pkg::HASH_STEPS)))
		else $error("home slot reduction overran");

	a_probe_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && probe_last) |=> (state_q == ST_DONE))
		else $error("probe loop went past one full pass");

endmodule
`default_nettype wire
